// ===== sv/vnf_pkg.sv =====
// Shared constants, register codes and helpers of the fractal value noise core.
// No dependencies; imported by vnf_octave and value_noise_fbm_3d_core.
package vnf_pkg;

  // hash multipliers
  localparam logic [31:0] HASH_C1 = 32'd374761393;
  localparam logic [31:0] HASH_C2 = 32'd668265263;
  localparam logic [31:0] HASH_C3 = 32'd1274126177;
  localparam logic [31:0] HASH_C4 = 32'd2246822519;
  localparam logic [31:0] HASH_C5 = 32'd3266489917;
  localparam logic [31:0] HASH_C6 = 32'd3812015801;

  localparam int unsigned FREQ_W   = 56;  // unsigned Q48.8
  localparam int unsigned VAL_W    = 24;  // corner value Q0.24
  localparam int unsigned NS_W     = 26;  // octave sample, signed Q1.24
  localparam int unsigned LANE_LAT = 10;  // register stages in one octave lane
  localparam int unsigned DIV_BITS = 16;

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(256);
  localparam logic [15:0]       AMP_ONE  = 16'd32768;

  typedef enum logic [1:0] {
    REG_SEED   = 2'd0,
    REG_OCT    = 2'd1,
    REG_LAC    = 2'd2,
    REG_GAIN   = 2'd3
  } cfg_reg_e;

  // floor((a*(1-s) + b*s)) with s in Q0.16
  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [16:0] s);
    logic [40:0] pa;
    logic [40:0] pb;
    logic [41:0] acc;
    pa  = a * (17'h10000 - s);
    pb  = b * s;
    acc = 42'(pa) + 42'(pb);
    return acc[39:16];
  endfunction

endpackage

// ===== sv/vnf_octave.sv =====
// One octave lane: scales the point, hashes the 8 lattice corners, blends them
// trilinearly and weights the sample by the octave amplitude. Uses vnf_pkg.
module vnf_octave #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned AMP_W = 23
) (
  input  logic                                      clk_i,
  input  logic [31:0]                               seed_i,
  input  logic [31:0]                               coord_x_i,
  input  logic [31:0]                               coord_y_i,
  input  logic [31:0]                               coord_z_i,
  input  logic [vnf_pkg::FREQ_W-1:0]                freq_i,
  input  logic [AMP_W-1:0]                          amp_i,
  output logic signed [vnf_pkg::NS_W+AMP_W-1:0]     prod_o,
  output logic [AMP_W-1:0]                          amp_o
);
  import vnf_pkg::*;

  localparam int unsigned FR = COORD_FRAC_BITS;

  // amplitude rides along until the weighting stage
  logic [AMP_W-1:0] ad_q [LANE_LAT-1];

  // scale
  logic signed [60:0] pl_d [3];
  logic signed [60:0] ph_d [3];
  logic signed [60:0] pl_q [3];
  logic signed [60:0] ph_q [3];
  logic [63:0]        pp   [3];
  logic [31:0]        cell_d [3];
  logic [15:0]        t_d  [3];
  logic [31:0]        cell_q [3];
  logic [15:0]        t_q  [3];

  // hash and smoothstep
  logic [31:0] sc_q;
  logic [31:0] xa_q [2];
  logic [31:0] yb_q [2];
  logic [31:0] yb2_q [2];
  logic [31:0] zc_q [2];
  logic [31:0] zc2_q [2];
  logic [31:0] zc3_q [2];
  logic [31:0] h2_q [2];
  logic [31:0] h3_q [4];
  logic [VAL_W-1:0] c_q [8];
  logic [15:0] t1_q [3];
  logic [31:0] t2_q [3];
  logic [31:0] t2b_q [3];
  logic [47:0] t3_q [3];
  logic [16:0] s3_q [3];
  logic [16:0] s4_q [3];
  logic [50:0] e_d [3];

  // blend
  logic [VAL_W-1:0] xl_q [4];
  logic [VAL_W-1:0] yl_q [2];
  logic [VAL_W-1:0] v_q;
  logic [16:0] sy1_q, sz1_q, sz2_q;
  logic signed [NS_W-1:0] ns;

  function automatic logic [31:0] mix_a(input logic [31:0] h);
    return (h ^ (h >> 13)) * HASH_C3;
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] h);
    return (h ^ (h >> 16)) * HASH_C5;
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pp[a]     = 64'(pl_q[a]) + (64'(ph_q[a]) << 28);
      cell_d[a] = pp[a][8+FR+31 -: 32];
      e_d[a]    = (51'(t2b_q[a]) << 17) + (51'(t2b_q[a]) << 16) - (51'(t3_q[a]) << 1);
    end
    pl_d[0] = $signed(coord_x_i) * $signed({1'b0, freq_i[27:0]});
    ph_d[0] = $signed(coord_x_i) * $signed({1'b0, freq_i[55:28]});
    pl_d[1] = $signed(coord_y_i) * $signed({1'b0, freq_i[27:0]});
    ph_d[1] = $signed(coord_y_i) * $signed({1'b0, freq_i[55:28]});
    pl_d[2] = $signed(coord_z_i) * $signed({1'b0, freq_i[27:0]});
    ph_d[2] = $signed(coord_z_i) * $signed({1'b0, freq_i[55:28]});
  end

  // fraction brought to Q0.16
  if (FR >= 16) begin : g_frac_trunc
    always_comb begin
      for (int a = 0; a < 3; a++) t_d[a] = pp[a][8+FR-16 +: 16];
    end
  end else begin : g_frac_pad
    always_comb begin
      for (int a = 0; a < 3; a++) t_d[a] = {pp[a][8 +: FR], {(16-FR){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q[0] <= amp_i;
    for (int i = 1; i < LANE_LAT - 1; i++) ad_q[i] <= ad_q[i-1];

    pl_q   <= pl_d;
    ph_q   <= ph_d;
    cell_q <= cell_d;
    t_q    <= t_d;

    sc_q <= seed_i * HASH_C1;
    for (int d = 0; d < 2; d++) begin
      xa_q[d] <= (cell_q[0] + 32'(d)) * HASH_C2;
      yb_q[d] <= (cell_q[1] + 32'(d)) * HASH_C4;
      zc_q[d] <= (cell_q[2] + 32'(d)) * HASH_C6;
    end
    for (int a = 0; a < 3; a++) begin
      t1_q[a]  <= t_q[a];
      t2_q[a]  <= t_q[a] * t_q[a];
      t3_q[a]  <= t2_q[a] * t1_q[a];
      t2b_q[a] <= t2_q[a];
      s3_q[a]  <= e_d[a][48:32];
      s4_q[a]  <= s3_q[a];
    end

    for (int d = 0; d < 2; d++) h2_q[d] <= mix_a(sc_q + xa_q[d]);
    yb2_q <= yb_q;
    zc2_q <= zc_q;

    for (int i = 0; i < 4; i++) h3_q[i] <= mix_b(h2_q[i % 2] + yb2_q[i / 2]);
    zc3_q <= zc2_q;

    for (int i = 0; i < 8; i++) begin
      c_q[i] <= VAL_W'((h3_q[i % 4] + zc3_q[i / 4]) ^ ((h3_q[i % 4] + zc3_q[i / 4]) >> 15));
    end

    for (int j = 0; j < 4; j++) xl_q[j] <= blend(c_q[2*j], c_q[2*j+1], s4_q[0]);
    sy1_q <= s4_q[1];
    sz1_q <= s4_q[2];

    for (int j = 0; j < 2; j++) yl_q[j] <= blend(xl_q[2*j], xl_q[2*j+1], sy1_q);
    sz2_q <= sz1_q;

    v_q <= blend(yl_q[0], yl_q[1], sz2_q);

    prod_o <= ns * $signed({1'b0, ad_q[LANE_LAT-2]});
    amp_o  <= ad_q[LANE_LAT-2];
  end

  // sample in [-1,1): 2v - 1
  assign ns = $signed({1'b0, v_q, 1'b0}) - $signed(NS_W'(26'h1000000));

endmodule

// ===== sv/value_noise_fbm_3d_core.sv =====
// Fractal value noise core, top level: config registers, octave parameter chain,
// octave lanes (vnf_octave), weighted sum, normalizing divider, output FIFO. Uses vnf_pkg.
//
//  channel   dir  word
//  s_axis    in   tdata[95:0] = coord_x, coord_y, coord_z (signed Q16.16 each)
//  m_axis    out  tdata[15:0] = noise_value (signed Q1.15)
//  cfg       in   we/idx/wdata, idx 0 seed, 1 octave_count, 2 lacunarity, 3 gain
//
// One word per cycle in and out while the ready signals allow. The octave parameter
// chain and the octave sum take one stage per octave, the divider one per
// quotient bit. The pipeline never stalls; an output FIFO absorbs results
// and s_axis_tready drops only while its credits are used up. Reset clears
// valids, credits and the FIFO pointers.
module value_noise_fbm_3d_core #(
  parameter int unsigned MAX_OCTAVES = 8,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // noise_value
);
  import vnf_pkg::*;

  localparam int unsigned NO    = MAX_OCTAVES;
  localparam int unsigned AW    = 15 + NO;
  localparam int unsigned CW    = $clog2(NO + 1);
  localparam int unsigned PW    = NS_W + AW;
  localparam int unsigned TW    = AW + CW;
  localparam int unsigned SW    = PW + CW;
  localparam int unsigned DW    = TW + DIV_BITS;
  localparam int unsigned DEPTH = 1 << $clog2(2 * NO + 32);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  // configuration
  logic [31:0] seed_q;
  logic [3:0]  oct_q;
  logic [15:0] lac_q;
  logic [15:0] gain_q;
  logic [CW-1:0] n_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= 4'd4;
      lac_q  <= 16'd512;
      gain_q <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SEED: seed_q <= cfg_wdata_i;
        REG_OCT:  oct_q  <= cfg_wdata_i[3:0];
        REG_LAC:  lac_q  <= cfg_wdata_i[15:0];
        REG_GAIN: gain_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign n_sat = ({1'b0, oct_q} > 5'(NO)) ? CW'(NO) : CW'(oct_q);

  // handshakes and credits
  logic in_acc, out_acc;
  logic [CNT_W-1:0] cred_q;

  assign s_axis_tready = cred_q < CNT_W'(DEPTH);
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // octave parameter chain: stage p fills frequency and amplitude of octave p
  logic [NO-1:0]       pv_q;
  logic [31:0]         pc_q [NO][3];
  logic [FREQ_W-1:0]   pf_q [NO][NO];
  logic [AW-1:0]       pa_q [NO][NO];
  logic [FREQ_W+15:0]  fm   [NO];
  logic [AW+15:0]      am   [NO];

  always_comb begin
    fm[0] = '0;
    am[0] = '0;
    for (int p = 1; p < NO; p++) begin
      fm[p] = pf_q[p-1][p-1] * lac_q;
      am[p] = pa_q[p-1][p-1] * gain_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q[0][0] <= s_axis_tdata[31:0];
    pc_q[0][1] <= s_axis_tdata[63:32];
    pc_q[0][2] <= s_axis_tdata[95:64];
    pf_q[0][0] <= FREQ_ONE;
    pa_q[0][0] <= (n_sat != '0) ? AW'(AMP_ONE) : '0;
    for (int p = 1; p < NO; p++) begin
      pc_q[p] <= pc_q[p-1];
      for (int q = 0; q < NO; q++) begin
        if (q == p) begin
          pf_q[p][q] <= fm[p][FREQ_W+7:8];
          pa_q[p][q] <= (CW'(p) < n_sat) ? am[p][AW+14:15] : '0;
        end else begin
          pf_q[p][q] <= pf_q[p-1][q];
          pa_q[p][q] <= pa_q[p-1][q];
        end
      end
    end
  end

  // octave lanes
  logic signed [PW-1:0] lp [NO];
  logic [AW-1:0]        la [NO];
  logic [LANE_LAT-1:0]  lv_q;

  for (genvar k = 0; k < NO; k++) begin : g_lane
    vnf_octave #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .AMP_W(AW)
    ) u_oct (
      .clk_i    (clk_i),
      .seed_i   (seed_q + 32'(k)),
      .coord_x_i(pc_q[NO-1][0]),
      .coord_y_i(pc_q[NO-1][1]),
      .coord_z_i(pc_q[NO-1][2]),
      .freq_i   (pf_q[NO-1][k]),
      .amp_i    (pa_q[NO-1][k]),
      .prod_o   (lp[k]),
      .amp_o    (la[k])
    );
  end

  // weighted sum, one octave per stage
  logic [NO-1:0]        av_q;
  logic signed [SW-1:0] ac_q [NO];
  logic [TW-1:0]        at_q [NO];
  logic signed [PW-1:0] ap_q [NO][NO];
  logic [AW-1:0]        aa_q [NO][NO];

  always_ff @(posedge clk_i) begin
    ac_q[0] <= SW'(lp[0]);
    at_q[0] <= TW'(la[0]);
    ap_q[0] <= lp;
    aa_q[0] <= la;
    for (int j = 1; j < NO; j++) begin
      ac_q[j] <= ac_q[j-1] + SW'(ap_q[j-1][j]);
      at_q[j] <= at_q[j-1] + TW'(aa_q[j-1][j]);
      ap_q[j] <= ap_q[j-1];
      aa_q[j] <= aa_q[j-1];
    end
  end

  // floor(sum / (total*512)) as unsigned restoring division of an offset numerator
  logic signed [SW-1:0]  num;
  logic [DIV_BITS:0]     dv_q;
  logic [DIV_BITS:0]     dz_q;
  logic [DW-1:0]         dr_q [DIV_BITS+1];
  logic [TW-1:0]         dt_q [DIV_BITS+1];
  logic [DIV_BITS-1:0]   dq_q [DIV_BITS+1];
  logic [DW-1:0]         dsub [DIV_BITS+1];
  logic [DIV_BITS:0]     dge;

  assign num = (ac_q[NO-1] >>> 9) + $signed(SW'({at_q[NO-1], 15'b0}));

  always_comb begin
    dsub[0] = '0;
    dge[0]  = 1'b0;
    for (int i = 1; i <= DIV_BITS; i++) begin
      dsub[i] = DW'(dt_q[i-1]) << (DIV_BITS - i);
      dge[i]  = dr_q[i-1] >= dsub[i];
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q[0] <= num[DW-1:0];
    dt_q[0] <= at_q[NO-1];
    dq_q[0] <= '0;
    for (int i = 1; i <= DIV_BITS; i++) begin
      dr_q[i] <= dge[i] ? dr_q[i-1] - dsub[i] : dr_q[i-1];
      dt_q[i] <= dt_q[i-1];
      dq_q[i] <= {dq_q[i-1][DIV_BITS-2:0], dge[i]};
    end
  end

  // valid and zero-octave flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      lv_q <= '0;
      av_q <= '0;
      dv_q <= '0;
      dz_q <= '0;
    end else begin
      pv_q <= {pv_q[NO-2:0], in_acc};
      lv_q <= {lv_q[LANE_LAT-2:0], pv_q[NO-1]};
      av_q <= {av_q[NO-2:0], lv_q[LANE_LAT-1]};
      dv_q <= {dv_q[DIV_BITS-1:0], av_q[NO-1]};
      dz_q <= {dz_q[DIV_BITS-1:0], at_q[NO-1] == '0};
    end
  end

  // output FIFO
  logic [15:0]      res;
  logic [15:0]      mem [DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] mc_q;
  logic             ov_q;
  logic [15:0]      od_q;
  logic             wr, pop;

  assign res = dz_q[DIV_BITS] ? 16'd0
             : {~dq_q[DIV_BITS][DIV_BITS-1], dq_q[DIV_BITS][DIV_BITS-2:0]};
  assign wr  = dv_q[DIV_BITS];
  assign pop = (mc_q != '0) && (!ov_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (wr) mem[wp_q] <= res;
    if (pop) od_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      mc_q   <= '0;
      ov_q   <= 1'b0;
      cred_q <= '0;
    end else begin
      if (wr)  wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      mc_q   <= mc_q + CNT_W'(wr) - CNT_W'(pop);
      cred_q <= cred_q + CNT_W'(in_acc) - CNT_W'(out_acc);
      if (pop) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

// ===== verif/value_noise_fbm_3d_core_tb.sv =====
// Testbench for value_noise_fbm_3d_core: directed and random points through the
// stream ports, checked against a fixed-point fBm value noise predictor. Uses vnf_pkg.
`timescale 1ns / 100ps

module value_noise_fbm_3d_core_tb;
  import vnf_pkg::*;

  localparam int unsigned MAX_OCT = 8;
  localparam int unsigned LATENCY = 2 * MAX_OCT + 29;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // coord_x, coord_y, coord_z
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // noise_value

  value_noise_fbm_3d_core uut (.*);

  // predictor copy of the registers
  logic [31:0] p_seed;
  logic [3:0]  p_oct;
  logic [15:0] p_lac;
  logic [15:0] p_gain;

  logic [15:0] noise_q[$];
  int          n_err;
  int          n_words_out;
  bit          quiet_in;      // no idling on the input side
  bit          quiet_out;     // no stalling on the output side
  int          hold_cycles;   // long output stall, counted down by the sink

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] corner_hash(logic [31:0] s, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z);
    logic [31:0] h;
    h = s * HASH_C1 + x * HASH_C2;
    h = (h ^ (h >> 13)) * HASH_C3;
    h = h + y * HASH_C4;
    h = (h ^ (h >> 16)) * HASH_C5;
    h = h + z * HASH_C6;
    return h ^ (h >> 15);
  endfunction

  function automatic logic [63:0] smooth_w(logic [15:0] t);
    logic [63:0] t2, t3;
    t2 = 64'(t) * 64'(t);
    t3 = t2 * 64'(t);
    return ((64'd3 * t2 * 64'd65536) - 64'd2 * t3) >> 32;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic longint octave_sample(logic [31:0] s, logic [31:0] c[3],
                                           logic [63:0] freq);
    logic [31:0] lat_pt[3];
    logic [63:0] sw[3];
    logic [63:0] p, cv[8], x00, x10, x01, x11, y0, y1, v;
    for (int a = 0; a < 3; a++) begin
      p = (64'($signed(c[a])) * freq) >> 8;
      lat_pt[a] = p[47:16];
      sw[a] = smooth_w(p[15:0]);
    end
    for (int i = 0; i < 8; i++)
      cv[i] = 64'(corner_hash(s, lat_pt[0] + 32'(i & 1), lat_pt[1] + 32'((i >> 1) & 1),
                              lat_pt[2] + 32'((i >> 2) & 1)) & 32'h00FF_FFFF);
    x00 = mix(cv[0], cv[1], sw[0]);
    x10 = mix(cv[2], cv[3], sw[0]);
    x01 = mix(cv[4], cv[5], sw[0]);
    x11 = mix(cv[6], cv[7], sw[0]);
    y0 = mix(x00, x10, sw[1]);
    y1 = mix(x01, x11, sw[1]);
    v = mix(y0, y1, sw[2]);
    return longint'(2 * v) - longint'(64'h0100_0000);
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] c[3]);
    int unsigned n;
    logic [63:0] freq, amp, total, den, mag;
    longint sum, res;
    n = (p_oct > MAX_OCT) ? MAX_OCT : p_oct;
    freq = 64'd256;
    amp = 64'd32768;
    total = 0;
    sum = 0;
    for (int unsigned k = 0; k < n; k++) begin
      sum += octave_sample(p_seed + k, c, freq) * longint'(amp);
      total += amp;
      amp = (amp * p_gain) >> 15;
      freq = ((freq * p_lac) >> 8) & 64'h00FF_FFFF_FFFF_FFFF;
    end
    if (total == 0) return 16'd0;
    den = total * 512;
    if (sum >= 0) res = longint'(64'(sum) / den);
    else begin
      mag = 64'(-sum);
      res = -longint'((mag + den - 1) / den);
    end
    return res[15:0];
  endfunction

  // write enable stays high across back to back writes; set_config drops it
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SEED: p_seed = val;
      REG_OCT:  p_oct = val[3:0];
      REG_LAC:  p_lac = val[15:0];
      REG_GAIN: p_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (noise_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] sd, logic [3:0] oc, logic [15:0] lc,
                            logic [15:0] gn);
    drain();
    write_reg(REG_SEED, sd);
    write_reg(REG_OCT, {28'd0, oc});
    write_reg(REG_LAC, {16'd0, lc});
    write_reg(REG_GAIN, {16'd0, gn});
    cfg_we_i <= 1'b0;
  endtask

  // one word in; the expectation is queued at acceptance
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] c[3];
    while (!quiet_in && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    c[0] = x;
    c[1] = y;
    c[2] = z;
    do @(posedge clk_i); while (!s_axis_tready);
    noise_q.push_back(fbm_noise(c));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16 | 32'($urandom_range(65535));
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0000_FFFF, 32'h0001_0000};
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
    send_point(32'h0003_8000, 32'hFFFE_4000, 32'h0);  // 2D use
    set_config(32'h8000_0000, 4'd0, 16'd512, 16'd16384);  // zero octaves
    send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    set_config(32'h7FFF_FFFF, 4'd15, 16'hFFFF, 16'hFFFF);  // count saturates
    send_point(32'h0001_8000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_0001, 32'h0, 32'h0002_0000);
    set_config(32'hFFFF_FFFF, 4'd8, 16'd0, 16'd0);  // amplitude and frequency hit zero
    send_point(32'h0005_4321, 32'hFFFA_1234, 32'h0000_0001);
    set_config(32'd0, 4'd1, 16'd256, 16'd32768);
    send_point(32'h0000_7FFF, 32'h0000_8000, 32'h0000_C000);
    // unknown index is not in the list of the two-bit port, nothing to write
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0)
        set_config($urandom(), 4'($urandom_range(15)),
                   $urandom_range(1) ? 16'($urandom_range(128, 768)) : 16'($urandom()),
                   16'($urandom()));
      quiet_in = (i % 300) >= 250;
      quiet_out = quiet_in;
      send_point(rand_coord(), rand_coord(), $urandom_range(3) == 0 ? 32'd0 : rand_coord());
    end
    quiet_in = 0;
    quiet_out = 0;
  endtask

  task automatic test_backpressure();
    set_config(32'd77, 4'd8, 16'd512, 16'd16384);
    hold_cycles = 400;
    quiet_in = 1;
    for (int i = 0; i < 120; i++) send_point($urandom(), $urandom(), $urandom());
    quiet_in = 0;
    drain();  // sender waits for every result
    for (int i = 0; i < 20; i++) send_point($urandom(), $urandom(), $urandom());
  endtask

  // sink and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words_out++;
        if (noise_q.size() == 0) begin
          $error("unexpected word: noise_value %0d", $signed(m_axis_tdata));
          n_err++;
        end else begin
          logic [15:0] want;
          want = noise_q.pop_front();
          if (want !== m_axis_tdata) begin
            $error("noise_value mismatch: expected %0d actual %0d",
                   $signed(want), $signed(m_axis_tdata));
            n_err++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else
        m_axis_tready <= quiet_out || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SEED;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    n_err = 0;
    n_words_out = 0;
    quiet_in = 0;
    quiet_out = 0;
    hold_cycles = 0;
    p_seed = 32'd0;
    p_oct = 4'd4;
    p_lac = 16'd512;
    p_gain = 16'd16384;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1000);
    test_backpressure();
    drain();
    $display("covered %0d noise words over directed extremes, random configs and backpressure",
             n_words_out);
    if (n_err == 0 && noise_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
